[rtl/acm_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// acm_pkg
// Shared types, constants and helpers of the argmax confusion matrix.
// ----------------------------------------------------------------------------
package acm_pkg;

    localparam int NUM_CLASSES = 4;
    localparam int COUNT_WIDTH = 16;

    localparam int CLS_W      = 3;
    localparam int MAT_SIZE   = NUM_CLASSES * NUM_CLASSES;
    localparam int ADDR_W     = (MAT_SIZE > 1) ? $clog2(MAT_SIZE) : 1;
    localparam int DIV_W      = COUNT_WIDTH + 16;
    localparam int DIV_CNT_W  = $clog2(DIV_W);
    localparam int ACC_W      = 17;

    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;
    localparam logic [ACC_W-1:0]       ACC_ONE   = 17'h10000;

    localparam logic [1:0] OP_SCORE = 2'd0;
    localparam logic [1:0] OP_CLEAR = 2'd1;
    localparam logic [1:0] OP_READ  = 2'd2;

    localparam logic KIND_ROW  = 1'b0;
    localparam logic KIND_READ = 1'b1;

    typedef struct packed {
        logic [1:0]        opcode;
        logic signed [15:0] score;
        logic              target_is_one;
        logic              end_of_row;
        logic [CLS_W-1:0]  read_row;
        logic [CLS_W-1:0]  read_col;
    } acm_in_t;

    typedef struct packed {
        logic              result_kind;
        logic [CLS_W-1:0]  predicted_class;
        logic [CLS_W-1:0]  target_class;
        logic              row_correct;
        logic [15:0]       entry_count;
        logic [15:0]       correct_count;
        logic [15:0]       total_count;
        logic [ACC_W-1:0]  accuracy_fraction;
    } acm_out_t;

    typedef struct packed {
        logic op_score;
        logic op_clear;
        logic op_read;
        logic look;
        logic load;
        logic step;
    } acm_cmd_t;

    typedef struct packed {
        logic div_done;
    } acm_status_t;

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_LOOK = 5'b00010,
        ST_LOAD = 5'b00100,
        ST_DIV  = 5'b01000,
        ST_OUT  = 5'b10000
    } acm_state_t;

    function automatic logic [COUNT_WIDTH-1:0] sat_inc(input logic [COUNT_WIDTH-1:0] v);
        return (v == COUNT_MAX) ? v : v + COUNT_WIDTH'(1);
    endfunction

endpackage

[rtl/acm_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// acm_ctrl
// Sequencer: accepts beats, runs matrix lookup, divider and result handoff.
// ----------------------------------------------------------------------------
module acm_ctrl
    import acm_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        item_valid,
    output logic        item_ready,
    input  logic [1:0]  opcode,
    input  logic        end_of_row,
    output logic        result_valid,
    input  logic        result_ready,
    output acm_cmd_t    cmd,
    input  acm_status_t status
);

    acm_state_t state_reg, state_next;
    logic       accept;

    assign item_ready   = (state_reg == ST_IDLE);
    assign result_valid = (state_reg == ST_OUT);
    assign accept       = item_valid && item_ready;

    always_comb
    begin
        cmd          = '0;
        cmd.op_score = accept && (opcode == OP_SCORE);
        cmd.op_clear = accept && (opcode == OP_CLEAR);
        cmd.op_read  = accept && (opcode == OP_READ);
        cmd.look     = (state_reg == ST_LOOK);
        cmd.load     = (state_reg == ST_LOAD);
        cmd.step     = (state_reg == ST_DIV);
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if ((cmd.op_score && end_of_row) || cmd.op_read)
                    state_next = ST_LOOK;
            end
            ST_LOOK: state_next = ST_LOAD;
            ST_LOAD: state_next = ST_DIV;
            ST_DIV:
            begin
                if (status.div_done)
                    state_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (result_ready)
                    state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

[rtl/acm_datapath.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// acm_datapath
// Running argmax, confusion memory, saturating totals and serial divider.
// ----------------------------------------------------------------------------
module acm_datapath
    import acm_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  acm_in_t     item,
    input  acm_cmd_t    cmd,
    output acm_status_t status,
    output acm_out_t    result
);

    // row tracking
    logic signed [15:0]     best_score_reg;
    logic [CLS_W-1:0]       best_idx_reg;
    logic [CLS_W-1:0]       col_reg;
    logic [CLS_W-1:0]       tgt_reg;
    logic                   full_reg;

    // totals
    logic [COUNT_WIDTH-1:0] diag_reg;
    logic [COUNT_WIDTH-1:0] total_reg;

    // confusion memory
    logic [COUNT_WIDTH-1:0] mem [MAT_SIZE];
    logic [MAT_SIZE-1:0]    valid_reg;
    logic [COUNT_WIDTH-1:0] rd_data_reg;

    // captured request
    logic                   kind_reg;
    logic [CLS_W-1:0]       pred_reg;
    logic [CLS_W-1:0]       targ_reg;
    logic                   ok_reg;
    logic [ADDR_W-1:0]      addr_reg;
    logic                   in_range_reg;
    logic [COUNT_WIDTH-1:0] entry_reg;

    // divider
    logic [DIV_W-1:0]       dvd_reg;
    logic [DIV_W-1:0]       quo_reg;
    logic [COUNT_WIDTH-1:0] rem_reg;
    logic [DIV_CNT_W-1:0]   cnt_reg;

    logic signed [15:0]     score_s;
    logic                   take;
    logic                   col_last;
    logic [CLS_W-1:0]       cur_best;
    logic [CLS_W-1:0]       cur_tgt;
    logic                   row_end;
    logic                   capture;
    logic [ADDR_W-1:0]      row_addr;
    logic [ADDR_W-1:0]      read_addr;
    logic [ADDR_W-1:0]      rd_addr;
    logic                   read_in_range;
    logic [COUNT_WIDTH-1:0] old_entry;
    logic [COUNT_WIDTH-1:0] inc_entry;
    logic                   mem_wr;
    logic [COUNT_WIDTH:0]   rem_sh;
    logic [COUNT_WIDTH:0]   rem_diff;
    logic                   q_bit;
    logic [ACC_W-1:0]       acc;

    assign score_s  = item.score;
    assign take     = !full_reg && ((col_reg == '0) || (score_s >= best_score_reg));
    assign col_last = ({1'b0, col_reg} + 4'd1) >= 4'(NUM_CLASSES);
    assign cur_best = take ? col_reg : best_idx_reg;
    assign cur_tgt  = (!full_reg && item.target_is_one) ? col_reg : tgt_reg;
    assign row_end  = cmd.op_score && item.end_of_row;
    assign capture  = row_end || cmd.op_read;

    assign row_addr      = ADDR_W'(cur_tgt * NUM_CLASSES + cur_best);
    assign read_addr     = ADDR_W'(item.read_row * NUM_CLASSES + item.read_col);
    assign rd_addr       = cmd.op_read ? read_addr : row_addr;
    assign read_in_range = ({1'b0, item.read_row} < 4'(NUM_CLASSES))
                        && ({1'b0, item.read_col} < 4'(NUM_CLASSES));

    assign old_entry = valid_reg[addr_reg] ? rd_data_reg : '0;
    assign inc_entry = sat_inc(old_entry);
    assign mem_wr    = cmd.look && (kind_reg == KIND_ROW);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            best_score_reg <= '0;
            best_idx_reg   <= '0;
            col_reg        <= '0;
            tgt_reg        <= '0;
            full_reg       <= 1'b0;
        end
        else if (cmd.op_clear || row_end)
        begin
            best_score_reg <= '0;
            best_idx_reg   <= '0;
            col_reg        <= '0;
            tgt_reg        <= '0;
            full_reg       <= 1'b0;
        end
        else if (cmd.op_score && !full_reg)
        begin
            if (take)
            begin
                best_score_reg <= score_s;
                best_idx_reg   <= col_reg;
            end
            tgt_reg <= cur_tgt;
            if (col_last)
                full_reg <= 1'b1;
            else
                col_reg <= col_reg + CLS_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            diag_reg  <= '0;
            total_reg <= '0;
            valid_reg <= '0;
        end
        else if (cmd.op_clear)
        begin
            diag_reg  <= '0;
            total_reg <= '0;
            valid_reg <= '0;
        end
        else if (mem_wr)
        begin
            total_reg           <= sat_inc(total_reg);
            valid_reg[addr_reg] <= 1'b1;
            if (ok_reg)
                diag_reg <= sat_inc(diag_reg);
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_wr)
            mem[addr_reg] <= inc_entry;
        if (capture)
            rd_data_reg <= mem[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (capture)
        begin
            kind_reg     <= cmd.op_read ? KIND_READ : KIND_ROW;
            pred_reg     <= cmd.op_read ? item.read_col : cur_best;
            targ_reg     <= cmd.op_read ? item.read_row : cur_tgt;
            ok_reg       <= !cmd.op_read && (cur_best == cur_tgt);
            addr_reg     <= rd_addr;
            in_range_reg <= cmd.op_read ? read_in_range : 1'b1;
        end
        if (cmd.look)
            entry_reg <= (kind_reg == KIND_ROW) ? inc_entry
                       : (in_range_reg ? old_entry : '0);
    end

    // restoring divide of diag * 2^16 by total, one quotient bit per cycle
    assign rem_sh   = {rem_reg, dvd_reg[DIV_W-1]};
    assign rem_diff = rem_sh - {1'b0, total_reg};
    assign q_bit    = (rem_sh >= {1'b0, total_reg});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= '0;
        else if (cmd.load)
            cnt_reg <= '0;
        else if (cmd.step)
            cnt_reg <= cnt_reg + DIV_CNT_W'(1);
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            dvd_reg <= {diag_reg, 16'b0};
            quo_reg <= '0;
            rem_reg <= '0;
        end
        else if (cmd.step)
        begin
            dvd_reg <= {dvd_reg[DIV_W-2:0], 1'b0};
            quo_reg <= {quo_reg[DIV_W-2:0], q_bit};
            rem_reg <= q_bit ? rem_diff[COUNT_WIDTH-1:0] : rem_sh[COUNT_WIDTH-1:0];
        end
    end

    assign status.div_done = cmd.step && (cnt_reg == DIV_CNT_W'(DIV_W - 1));

    assign acc = (total_reg == '0)           ? '0
               : (quo_reg > DIV_W'(ACC_ONE)) ? ACC_ONE
               : quo_reg[ACC_W-1:0];

    always_comb
    begin
        result.result_kind       = kind_reg;
        result.predicted_class   = pred_reg;
        result.target_class      = targ_reg;
        result.row_correct       = ok_reg;
        result.entry_count       = 16'(entry_reg);
        result.correct_count     = 16'(diag_reg);
        result.total_count       = 16'(total_reg);
        result.accuracy_fraction = acc;
    end

    a_diag_le_total: assert property (@(posedge clk) disable iff (!rst_n)
        diag_reg <= total_reg)
        else $error("diagonal total exceeds row total");

    a_col_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        {1'b0, col_reg} < 4'(NUM_CLASSES))
        else $error("column position out of range");

    a_entry_marked: assert property (@(posedge clk) disable iff (!rst_n)
        mem_wr |=> valid_reg[$past(addr_reg)])
        else $error("written entry not marked valid");

    a_acc_bound: assert property (@(posedge clk) disable iff (!rst_n)
        status.div_done |=> (acc <= ACC_ONE))
        else $error("accuracy above one");

endmodule

[rtl/argmax_confusion_matrix.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// argmax_confusion_matrix
// Streaming argmax classifier scoring into a saturating confusion matrix.
// ----------------------------------------------------------------------------
// Score beats without end of row and clear beats: one per cycle, no result.
// Row end and read: result valid once the beat has passed the matrix lookup,
//   divider load and the bit-serial divider computing accuracy, in that order.
// One beat in flight at a time; input ready again once the result is taken.
// Reset (async, active low): matrix reads zero at once, totals and row cleared.
module argmax_confusion_matrix
    import acm_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     item_valid,
    output logic     item_ready,
    input  acm_in_t  item,
    output logic     result_valid,
    input  logic     result_ready,
    output acm_out_t result
);

    acm_cmd_t    cmd;
    acm_status_t status;

    acm_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .opcode       (item.opcode),
        .end_of_row   (item.end_of_row),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .cmd          (cmd),
        .status       (status)
    );

    acm_datapath u_datapath (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item),
        .cmd    (cmd),
        .status (status),
        .result (result)
    );

endmodule
